[design/window_3x3_convolution_filter_unit_defines.svh]
// Assertion macros shared by the checker of the 3x3 window filter unit.
`ifndef WINDOW_3X3_CONVOLUTION_FILTER_UNIT_DEFINES_SVH
`define WINDOW_3X3_CONVOLUTION_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define W3CF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define W3CF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/w3cf_pkg.sv]
// Types and constants shared by the 3x3 window filter unit.
package w3cf_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    MODE_BOX       = 3'd0,
    MODE_GAUSS     = 3'd1,
    MODE_PREWITT_X = 3'd2,
    MODE_PREWITT_Y = 3'd3,
    MODE_SOBEL_X   = 3'd4,
    MODE_SOBEL_Y   = 3'd5,
    MODE_LAPLACE   = 3'd6,
    MODE_LAPLACE_DC = 3'd7
  } w3cf_mode_e;

  localparam int unsigned SUM_W  = 13;
  localparam int unsigned MAG_W  = 12;
  localparam int unsigned RCP_W  = 25;
  localparam int unsigned PROD_W = MAG_W + RCP_W;

  // floor(S * 0.11111) == (S * ceil(2^28 * 0.11111)) >> 28 for S <= 2295
  localparam logic [RCP_W-1:0] BOX_RECIP  = 25'd29825864;
  localparam int unsigned      BOX_SHIFT  = 28;
  // floor(v / 3) == (v * 683) >> 11 for v <= 765
  localparam logic [RCP_W-1:0] DIV3_RECIP = 25'd683;
  localparam int unsigned      DIV3_SHIFT = 11;

  typedef logic [8:0][7:0] w3cf_win_t;

  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row;
    logic        last;
  } w3cf_side_t;

  typedef struct packed {
    logic [7:0] filtered;
    w3cf_side_t side;
  } w3cf_res_t;

endpackage

[design/window_3x3_convolution_filter_unit.sv]
// Top level of the 3x3 window filter unit: position counters, line store, window, output skid.
//
// Pixels enter in raster order and are taken one per clock while the skid word is empty; a
// result word passes a line-store read at the accepting edge, then window update, kernel sum,
// multiply and output register, so sustained throughput is one pixel per clock when the
// output is not stalled, set by the single read-modify-write access per pixel to the line
// store. A skid word behind the output register holds one more result, so input stops
// only once a word has been refused and the next result is waiting. Border pixels produce
// no word. The line store has no clearing pass: the first two rows of a frame fill it.
module window_3x3_convolution_filter_unit #(
  parameter int unsigned MAX_WIDTH  = w3cf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = w3cf_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pixel_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  filtered_o,
  output logic [10:0] center_col_o,
  output logic [10:0] center_row_o,
  output logic        frame_last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned W_RST = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
  localparam int unsigned H_RST = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;

  function automatic logic [31:0] clamp_size(input logic [11:0] v, input int unsigned hi);
    logic [31:0] r;
    r = 32'(v);
    if (r < 32'd3) begin
      r = 32'd3;
    end else if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

  w3cf_pkg::w3cf_mode_e mode_q;
  logic [CW-1:0]        width_q;
  logic [RW-1:0]        height_q;

  logic [CW-1:0]        col_q, col_d, cur_col, col_inc;
  logic [RW-1:0]        row_q, row_d, row_base, row_adv, cur_row, row_inc;
  logic                 emit;
  w3cf_pkg::w3cf_side_t side;

  logic                 en;
  logic                 accept;

  logic                 s1_valid_q;
  logic                 s1_emit_q;
  logic [7:0]           s1_px_q;
  logic [AW-1:0]        s1_addr_q;
  w3cf_pkg::w3cf_side_t s1_side_q;
  logic                 fwd_hit_q;
  logic [15:0]          fwd_data_q;

  logic [15:0]          rd_data;
  logic [15:0]          line_data;
  logic [15:0]          wr_data;
  logic                 wr_en;

  w3cf_pkg::w3cf_win_t  window_q;
  logic                 s2_valid_q;
  w3cf_pkg::w3cf_side_t s2_side_q;

  logic                 tail_valid;
  logic [7:0]           tail_data;
  w3cf_pkg::w3cf_side_t tail_side;

  logic                 out_valid_q, skid_valid_q;
  w3cf_pkg::w3cf_res_t  out_q, skid_q, tail_res;

  // configuration; sizes are clamped on write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= w3cf_pkg::MODE_BOX;
      width_q  <= CW'(W_RST);
      height_q <= RW'(H_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        w3cf_pkg::REG_MODE:   mode_q   <= w3cf_pkg::w3cf_mode_e'(cfg_data_i[2:0]);
        w3cf_pkg::REG_WIDTH:  width_q  <= CW'(clamp_size(cfg_data_i, MAX_WIDTH));
        w3cf_pkg::REG_HEIGHT: height_q <= RW'(clamp_size(cfg_data_i, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  assign en         = !skid_valid_q;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // position of the incoming pixel, with wrap for a stale position after a size change
  always_comb begin
    cur_col  = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : row_q;
    row_adv  = row_base;
    if (cur_col >= width_q) begin
      cur_col = '0;
      row_adv = row_base + RW'(1);
    end
    cur_row = (row_adv >= height_q) ? '0 : row_adv;

    emit      = (cur_row >= RW'(2)) && (cur_col >= CW'(2));
    side.col  = 11'(32'(cur_col) - 32'd1);
    side.row  = 11'(32'(cur_row) - 32'd1);
    side.last = (cur_row == height_q - RW'(1)) && (cur_col == width_q - CW'(1));

    col_inc = cur_col + CW'(1);
    row_inc = cur_row + RW'(1);
    if (col_inc >= width_q) begin
      col_d = '0;
      row_d = (row_inc >= height_q) ? '0 : row_inc;
    end else begin
      col_d = col_inc;
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  w3cf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (cur_col[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data)
  );

  // a back-to-back hit on the same column sees the word written in the same cycle
  assign line_data = fwd_hit_q ? fwd_data_q : rd_data;
  assign wr_data   = {line_data[7:0], s1_px_q};
  assign wr_en     = en && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
      fwd_hit_q  <= accept && s1_valid_q && (s1_addr_q == cur_col[AW-1:0]);
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_addr_q <= cur_col[AW-1:0];
      s1_emit_q <= emit;
      s1_side_q <= side;
    end
    if (en) begin
      fwd_data_q <= wr_data;
      s2_side_q  <= s1_side_q;
    end
  end

  // sliding window: columns move left, new column is top / mid / incoming pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (en && s1_valid_q) begin
      window_q[0] <= window_q[1];
      window_q[1] <= window_q[2];
      window_q[2] <= line_data[15:8];
      window_q[3] <= window_q[4];
      window_q[4] <= window_q[5];
      window_q[5] <= line_data[7:0];
      window_q[6] <= window_q[7];
      window_q[7] <= window_q[8];
      window_q[8] <= s1_px_q;
    end
  end

  w3cf_filter_dp u_filter_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .mode_i      (mode_q),
    .in_valid_i  (s2_valid_q),
    .win_i       (window_q),
    .side_i      (s2_side_q),
    .out_valid_o (tail_valid),
    .out_data_o  (tail_data),
    .out_side_o  (tail_side)
  );

  assign tail_res.filtered = tail_data;
  assign tail_res.side     = tail_side;

  // output register plus skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !out_ready_i) begin
      if (en && tail_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= tail_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_ready_i) begin
      if (en && tail_valid) begin
        skid_q <= tail_res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= tail_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_o   = out_q.filtered;
  assign center_col_o = out_q.side.col;
  assign center_row_o = out_q.side.row;
  assign frame_last_o = out_q.side.last;

endmodule

[design/w3cf_line_store.sv]
// Two-row line store: one word per column holds the two rows above the pixel.
module w3cf_line_store #(
  parameter int unsigned DEPTH = w3cf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [15:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [15:0]   wr_data_i
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read-before-write on a same-address collision; caller forwards
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/w3cf_filter_dp.sv]
// Filter datapath: kernel sum, magnitude and reciprocal multiply, final scaling.
module w3cf_filter_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  w3cf_pkg::w3cf_mode_e   mode_i,
  input  logic                   in_valid_i,
  input  w3cf_pkg::w3cf_win_t    win_i,
  input  w3cf_pkg::w3cf_side_t   side_i,
  output logic                   out_valid_o,
  output logic [7:0]             out_data_o,
  output w3cf_pkg::w3cf_side_t   out_side_o
);

  logic signed [w3cf_pkg::SUM_W-1:0] p [9];
  logic signed [w3cf_pkg::SUM_W-1:0] others;
  logic signed [w3cf_pkg::SUM_W-1:0] sum_d;

  logic                              a_valid_q;
  logic signed [w3cf_pkg::SUM_W-1:0] a_sum_q;
  w3cf_pkg::w3cf_side_t              a_side_q;

  logic [w3cf_pkg::MAG_W-1:0]        mag;
  logic [w3cf_pkg::RCP_W-1:0]        recip;
  logic [w3cf_pkg::PROD_W-1:0]       prod_d;

  logic                              b_valid_q;
  logic [w3cf_pkg::PROD_W-1:0]       b_prod_q;
  logic [w3cf_pkg::MAG_W-1:0]        b_mag_q;
  logic signed [w3cf_pkg::SUM_W-1:0] b_sum_q;
  w3cf_pkg::w3cf_side_t              b_side_q;

  // stage A: signed kernel sum
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = $signed({5'b0, win_i[i]});
    end
    others = p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8];
    unique case (mode_i)
      w3cf_pkg::MODE_BOX:        sum_d = others + p[4];
      w3cf_pkg::MODE_GAUSS:      sum_d = p[0] + (p[1] <<< 1) + p[2] + (p[3] <<< 1)
                                       + (p[4] <<< 2) + (p[5] <<< 1) + p[6]
                                       + (p[7] <<< 1) + p[8];
      w3cf_pkg::MODE_PREWITT_X:  sum_d = (p[2] + p[5] + p[8]) - (p[0] + p[3] + p[6]);
      w3cf_pkg::MODE_PREWITT_Y:  sum_d = (p[6] + p[7] + p[8]) - (p[0] + p[1] + p[2]);
      w3cf_pkg::MODE_SOBEL_X:    sum_d = (p[2] + (p[5] <<< 1) + p[8])
                                       - (p[0] + (p[3] <<< 1) + p[6]);
      w3cf_pkg::MODE_SOBEL_Y:    sum_d = (p[6] + (p[7] <<< 1) + p[8])
                                       - (p[0] + (p[1] <<< 1) + p[2]);
      w3cf_pkg::MODE_LAPLACE:    sum_d = (p[4] <<< 3) - others;
      w3cf_pkg::MODE_LAPLACE_DC: sum_d = (p[4] <<< 3) + p[4] - others;
    endcase
  end

  // stage B: magnitude and one reciprocal multiply (box mean or divide by 3)
  always_comb begin
    mag   = a_sum_q[w3cf_pkg::SUM_W-1] ? w3cf_pkg::MAG_W'(-a_sum_q)
                                       : w3cf_pkg::MAG_W'(a_sum_q);
    recip = (mode_i == w3cf_pkg::MODE_BOX) ? w3cf_pkg::BOX_RECIP : w3cf_pkg::DIV3_RECIP;
    prod_d = mag * recip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sum_q  <= sum_d;
      a_side_q <= side_i;
      b_prod_q <= prod_d;
      b_mag_q  <= mag;
      b_sum_q  <= a_sum_q;
      b_side_q <= a_side_q;
    end
  end

  // final scaling
  always_comb begin
    unique case (mode_i)
      w3cf_pkg::MODE_BOX:        out_data_o = 8'(b_prod_q >> w3cf_pkg::BOX_SHIFT);
      w3cf_pkg::MODE_GAUSS:      out_data_o = 8'(b_mag_q >> 4);
      w3cf_pkg::MODE_PREWITT_X,
      w3cf_pkg::MODE_PREWITT_Y:  out_data_o = 8'(b_prod_q >> w3cf_pkg::DIV3_SHIFT);
      w3cf_pkg::MODE_SOBEL_X,
      w3cf_pkg::MODE_SOBEL_Y:    out_data_o = 8'(b_mag_q >> 2);
      w3cf_pkg::MODE_LAPLACE:    out_data_o = 8'(b_mag_q >> 3);
      w3cf_pkg::MODE_LAPLACE_DC: begin
        if (b_sum_q < 0) begin
          out_data_o = 8'd0;
        end else if (b_sum_q > 13'sd255) begin
          out_data_o = 8'd255;
        end else begin
          out_data_o = 8'(b_sum_q);
        end
      end
    endcase
  end

  assign out_valid_o = b_valid_q;
  assign out_side_o  = b_side_q;

endmodule

[design/w3cf_checker.sv]
// Port-level checker for the 3x3 window filter unit, bound to the top level.
`include "window_3x3_convolution_filter_unit_defines.svh"

module w3cf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [11:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  pixel_i,
  input logic        frame_start_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  filtered_o,
  input logic [10:0] center_col_o,
  input logic [10:0] center_row_o,
  input logic        frame_last_o
);

  // input is held off only while both output words are occupied
  `W3CF_ASSERT_IMPL(a_busy_means_full, !in_ready_o, out_valid_o, "input stalled with output empty")

  // input back-pressure starts only after a refused output word
  `W3CF_ASSERT_IMPL(a_ready_fall, $fell(in_ready_o), $past(out_valid_o && !out_ready_i), "input stalled without output stall")

  // a refused word stays on the port unchanged
  `W3CF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(filtered_o) && $stable(center_col_o) && $stable(center_row_o) && $stable(frame_last_o), "output word changed while stalled")

endmodule

bind window_3x3_convolution_filter_unit w3cf_checker u_w3cf_checker (.*);

[tb/window_3x3_convolution_filter_unit_tb.sv]
// Self-checking testbench for the 3x3 window filter unit: predicted result words vs. DUT output.
`timescale 1ns / 100ps

module window_3x3_convolution_filter_unit_tb;
  import w3cf_pkg::*;

  // worst case ~1k pixels under full output stalls and input gaps, plus register writes
  // and drains, taken several times over
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef enum logic {PIX_ANY, PIX_RAILS} pix_style_e;

  class filtered_pixel_tracker;
    w3cf_mode_e  mode;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [7:0]  line_up2 [MAX_WIDTH_DEF];
    logic [7:0]  line_up1 [MAX_WIDTH_DEF];
    bit          up2_written [MAX_WIDTH_DEF];
    bit          up1_written [MAX_WIDTH_DEF];
    logic [7:0]  win [9];
    int unsigned col_cnt;
    int unsigned row_cnt;
    w3cf_res_t   expected_words [$];
    int unsigned mismatches;

    function new();
      mode       = MODE_BOX;
      width_reg  = 12'd512;
      height_reg = 12'd512;
      foreach (win[k]) win[k] = 8'd0;
      foreach (up2_written[k]) begin
        up2_written[k] = 1'b0;
        up1_written[k] = 1'b0;
      end
      col_cnt    = 0;
      row_cnt    = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_size(logic [11:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return 32'(v);
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] data);
      case (idx)
        REG_MODE:   mode = w3cf_mode_e'(data[2:0]);
        REG_WIDTH:  width_reg = data;
        REG_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    // both line rows hold real pixels for every column of the current width
    function bit lines_ready();
      int unsigned w;
      w = clamp_size(width_reg, MAX_WIDTH_DEF);
      for (int unsigned c = 0; c < w; c++)
        if (!(up2_written[c] && up1_written[c])) return 1'b0;
      return 1'b1;
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function logic [7:0] window_response();
      int p [9];
      int ring;
      int acc;
      foreach (win[k]) p[k] = int'(win[k]);
      ring = p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8];
      case (mode)
        MODE_BOX:       acc = (ring + p[4]) * 11111 / 100000;
        MODE_GAUSS:     acc = (p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] + 2 * p[5]
                               + p[6] + 2 * p[7] + p[8]) / 16;
        MODE_PREWITT_X: acc = magnitude((p[2] + p[5] + p[8]) - (p[0] + p[3] + p[6])) / 3;
        MODE_PREWITT_Y: acc = magnitude((p[6] + p[7] + p[8]) - (p[0] + p[1] + p[2])) / 3;
        MODE_SOBEL_X:   acc = magnitude((p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6])) / 4;
        MODE_SOBEL_Y:   acc = magnitude((p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2])) / 4;
        MODE_LAPLACE:   acc = magnitude(8 * p[4] - ring) / 8;
        default: begin
          // laplace with dc term, saturated to a byte
          acc = 9 * p[4] - ring;
          if (acc < 0) acc = 0;
          if (acc > 255) acc = 255;
        end
      endcase
      return acc[7:0];
    endfunction

    function void take_pixel(logic [7:0] px, logic fs);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic [7:0]  up2;
      logic [7:0]  up1;
      w3cf_res_t   word;
      w = clamp_size(width_reg, MAX_WIDTH_DEF);
      h = clamp_size(height_reg, MAX_HEIGHT_DEF);
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      // counters left past the size by a size change wrap before the pixel is placed
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      c = col_cnt;
      r = row_cnt;

      up2            = line_up2[c];
      up1            = line_up1[c];
      line_up2[c]    = up1;
      line_up1[c]    = px;
      up2_written[c] = up1_written[c];
      up1_written[c] = 1'b1;

      for (int k = 0; k < 9; k += 3) begin
        win[k]     = win[k + 1];
        win[k + 1] = win[k + 2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = px;

      if (r >= 2 && c >= 2) begin
        word.filtered  = window_response();
        word.side.col  = 11'(c - 1);
        word.side.row  = 11'(r - 1);
        word.side.last = (r == h - 1) && (c == w - 1);
        expected_words.push_back(word);
      end

      col_cnt = c + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = r + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("%0t MISMATCH %s", $time, msg);
    endtask

    task match_word(w3cf_res_t got);
      w3cf_res_t want;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("word with no pending pixel: col %0d row %0d",
                                got.side.col, got.side.row));
        return;
      end
      want = expected_words.pop_front();
      if (got.filtered !== want.filtered)
        flag_mismatch($sformatf("filtered %0d, want %0d (col %0d row %0d)",
                                got.filtered, want.filtered, want.side.col, want.side.row));
      if (got.side.col !== want.side.col)
        flag_mismatch($sformatf("center_col %0d, want %0d", got.side.col, want.side.col));
      if (got.side.row !== want.side.row)
        flag_mismatch($sformatf("center_row %0d, want %0d", got.side.row, want.side.row));
      if (got.side.last !== want.side.last)
        flag_mismatch($sformatf("frame_last %0b, want %0b (col %0d row %0d)",
                                got.side.last, want.side.last, want.side.col, want.side.row));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [1:0]  cfg_index_i   = REG_MODE;
  logic [11:0] cfg_data_i    = 12'd0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  pixel_i       = 8'd0;
  logic        frame_start_i = 1'b0;
  logic        out_ready_i   = 1'b1;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  filtered_o;
  logic [10:0] center_col_o;
  logic [10:0] center_row_o;
  logic        frame_last_o;

  filtered_pixel_tracker tracker;
  int unsigned           burst_left = 0;
  int unsigned           rx_hold    = 0;
  int unsigned           cycle_cnt  = 0;

  window_3x3_convolution_filter_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .filtered_o   (filtered_o),
    .center_col_o (center_col_o),
    .center_row_o (center_row_o),
    .frame_last_o (frame_last_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // receiver: short or long stalls between ready runs of varying length
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
    end else if (out_ready_i) begin
      out_ready_i <= 1'b0;
      rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
      rx_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 6);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.match_word({filtered_o, center_col_o, center_row_o, frame_last_o});
    end
  end

  function automatic logic [11:0] pick_size(int unsigned odds);
    case ($urandom_range(0, odds))
      0:       return 12'($urandom_range(0, 2));
      1:       return ($urandom_range(0, 1) != 0) ? 12'd2048 : 12'($urandom_range(2049, 4095));
      2:       return 12'd3;
      default: return 12'($urandom_range(4, 24));
    endcase
  endfunction

  function automatic logic [7:0] next_pixel(pix_style_e style);
    if (style == PIX_RAILS) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // called at a falling edge with the channel idle; returns at a fresh falling edge
  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // valid stays up across back-to-back words; it only drops for a gap or in settle()
  task automatic send_word(logic [7:0] px, logic fs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_pixel(px, fs);
    @(negedge clk_i);
  endtask

  // border pixels give no word, so the pipeline may still be busy once the queue drains
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned sent;
    w3cf_mode_e  cur_mode;
    pix_style_e  style;
    logic        fresh;
    logic        fs;

    tracker = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // mode after reset is box mean; a white 3x3 frame gives one word
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd3);
    for (i = 0; i < 9; i++) send_word(8'hFF, i == 0);
    settle();

    write_reg(REG_MODE, {9'd0, MODE_LAPLACE_DC});
    // bright center on black saturates high, then dark center on white saturates low;
    // the second frame relies on the counters wrapping on their own
    for (i = 0; i < 9; i++) send_word((i == 4) ? 8'hFF : 8'h00, i == 0);
    for (i = 0; i < 9; i++) send_word((i == 4) ? 8'h00 : 8'hFF, 1'b0);
    settle();

    write_reg(REG_UNUSED, 12'($urandom));
    cur_mode = MODE_LAPLACE_DC;
    sent     = 0;
    while (sent < RANDOM_ITEMS) begin
      cur_mode = cur_mode.next();
      if ($urandom_range(0, 3) != 0) write_reg(REG_WIDTH, pick_size(8));
      if ($urandom_range(0, 3) != 0) write_reg(REG_HEIGHT, pick_size(3));
      write_reg(REG_MODE, {9'($urandom), cur_mode});
      style = ($urandom_range(0, 2) == 0) ? PIX_RAILS : PIX_ANY;
      n     = $urandom_range(20, 110);
      // restart the frame when a wider row would read line entries never filled
      fresh = !tracker.lines_ready() || ($urandom_range(0, 4) == 0);
      for (i = 0; i < n; i++) begin
        fs = (i == 0) ? fresh : ($urandom_range(0, 149) == 0);
        send_word(next_pixel(style), fs);
      end
      settle();
      sent += n;
    end

    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/w3cf_pkg.sv
design/w3cf_line_store.sv
design/w3cf_filter_dp.sv
design/window_3x3_convolution_filter_unit.sv
design/w3cf_checker.sv
tb/window_3x3_convolution_filter_unit_tb.sv
